// File: rtl/swsr_pkg.sv
// Package for the stack with search-and-remove: sizes, codes and beat types.
package swsr_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 31;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  position;
      logic [1:0]        status;
      logic [CNT_W-1:0]  fill;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_RD,
      S_SCAN,
      S_RESP
   } state_type;

endpackage

// File: rtl/stack_with_search_remove_unit.sv
// Top level of the LIFO stack with push, pop and remove-by-value.
//
// Input channel req_: one beat carries a command (push, pop, remove) and a
// value. A beat is taken when req_valid is high and req_stall low. The unit
// works on one command at a time and holds req_stall high until it is done.
// Result channel rsp_: exactly one beat per command with popped data, the
// position of the topmost match on remove, a status code and the fill level.
// Per command: a push, an empty pop or an unused code sets its result
// straight from idle; a pop first reads the top entry from the RAM; a
// remove walks the stack bottom to top, one entry read and compared per
// cycle through the single RAM read port, kept entries written back
// behind the read pointer.
// A new command is taken only once the previous result has moved into
// the output register, which a stalled, full output register holds off.
// The result sits in an output register, so a new command is taken while a
// finished result still waits; a stalled result beat holds unchanged.
// Reset (synchronous, active high) empties the stack; RAM contents are not
// cleared as only written slots are ever read.
module stack_with_search_remove_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  swsr_pkg::req_type req_item,
   output logic              req_stall,
   output logic              rsp_valid,
   output swsr_pkg::rsp_type rsp_item,
   input  logic              rsp_stall
);
   import swsr_pkg::*;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;
   logic              res_valid;
   rsp_type           res_item;
   logic              res_taken;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   swsr_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (mem_req.we),
      .waddr(mem_req.waddr),
      .wdata(mem_req.wdata),
      .re   (mem_req.re),
      .raddr(mem_req.raddr),
      .rdata(mem_rdata)
   );

   swsr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_item (req_item),
      .req_stall(req_stall),
      .res_valid(res_valid),
      .res_item (res_item),
      .res_taken(res_taken),
      .mem_req  (mem_req),
      .mem_rdata(mem_rdata)
   );

   // output slot loads when empty or when its beat leaves this cycle
   always_comb begin
      res_taken    = res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_taken) begin
         rsp_item_in  = res_item;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: rtl/swsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swsr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/swsr_core.sv
// Command sequencer: push, pop and the compare-and-compact walk for remove.
module swsr_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  swsr_pkg::req_type       req_item,
   output logic                    req_stall,
   output logic                    res_valid,
   output swsr_pkg::rsp_type       res_item,
   input  logic                    res_taken,
   output swsr_pkg::mem_req_type   mem_req,
   input  logic [swsr_pkg::DATA_W-1:0] mem_rdata
);
   import swsr_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pidx_ff, pidx_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] hit_ff, hit_in;
   rsp_type           res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
      pidx_ff <= pidx_in;
      hit_ff  <= hit_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      hit_in    = hit_ff;
      res_in    = res_ff;
      mem_req   = '0;
      req_stall = 1'b1;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               key_in = req_item.value;
               unique case (req_item.command)
                  CMD_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        res_in = '{data: '0, position: '0, status: ST_FULL, fill: count_ff};
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff[ADDR_W-1:0];
                        mem_req.wdata = req_item.value;
                        count_in      = CNT_W'(count_ff + 1'b1);
                        res_in        = '{data: '0, position: '0, status: ST_OK,
                                          fill: CNT_W'(count_ff + 1'b1)};
                     end
                     state_in = S_RESP;
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        res_in   = '{data: '0, position: '0, status: ST_EMPTY, fill: count_ff};
                        state_in = S_RESP;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = ADDR_W'(count_ff - 1'b1);
                        count_in      = CNT_W'(count_ff - 1'b1);
                        state_in      = S_POP_RD;
                     end
                  end
                  CMD_REMOVE: begin
                     rd_in    = '0;
                     wr_in    = '0;
                     pend_in  = 1'b0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in   = '{data: '0, position: '0, status: ST_OK, fill: count_ff};
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_POP_RD: begin
            res_in   = '{data: mem_rdata, position: '0, status: ST_OK, fill: count_ff};
            state_in = S_RESP;
         end
         S_SCAN: begin
            // compare the entry read last cycle; keep it by writing it down
            if (pend_ff) begin
               if (mem_rdata == key_ff) begin
                  found_in = 1'b1;
                  hit_in   = pidx_ff;
               end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = wr_ff[ADDR_W-1:0];
                  mem_req.wdata = mem_rdata;
                  wr_in         = CNT_W'(wr_ff + 1'b1);
               end
            end
            // write slot always trails the read slot, so no hazard
            if (rd_ff < count_ff) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = rd_ff[ADDR_W-1:0];
               pidx_in       = rd_ff[ADDR_W-1:0];
               rd_in         = CNT_W'(rd_ff + 1'b1);
               pend_in       = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (found_ff) begin
                     res_in   = '{data: '0,
                                  position: CNT_W'(count_ff - {1'b0, hit_ff}),
                                  status: ST_OK, fill: wr_ff};
                     count_in = wr_ff;
                  end else begin
                     res_in = '{data: '0, position: '0, status: ST_NOTFOUND, fill: count_ff};
                  end
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_item = res_ff;

endmodule

// File: verif/stack_result_checker.sv
`timescale 1ns / 1ps
// Checker for the stack unit: mirrors the stack and compares every result beat.
module stack_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  swsr_pkg::req_type req_item,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  swsr_pkg::rsp_type rsp_item,
   input  logic              rsp_stall,
   output int                mismatches,
   output int                results_due
);
   import swsr_pkg::*;

   logic [DATA_W-1:0] shadow_stack [DEPTH];
   int                shadow_fill;
   rsp_type           due_q [$];
   int                beat_no;

   initial begin
      mismatches  = 0;
      results_due = 0;
      shadow_fill = 0;
      beat_no     = 0;
   end

   // Applies one command to the shadow stack and returns the beat it should produce.
   function automatic rsp_type stack_outcome(input req_type cmd_beat);
      rsp_type res;
      int      kept;
      int      top_hit;
      bit      found;
      res     = '0;
      kept    = 0;
      top_hit = 0;
      found   = 1'b0;
      res.status = ST_OK;
      case (cmd_beat.command)
         CMD_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_stack[shadow_fill] = cmd_beat.value;
               shadow_fill++;
            end
         end
         CMD_POP: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_fill--;
               res.data = shadow_stack[shadow_fill];
            end
         end
         CMD_REMOVE: begin
            // compact survivors downwards; last hit seen is the topmost
            for (int rd = 0; rd < shadow_fill; rd++) begin
               if (shadow_stack[rd] == cmd_beat.value) begin
                  found   = 1'b1;
                  top_hit = rd;
               end else begin
                  shadow_stack[kept] = shadow_stack[rd];
                  kept++;
               end
            end
            if (found) begin
               res.position = CNT_W'(shadow_fill - top_hit);
               shadow_fill  = kept;
            end else begin
               res.status = ST_NOTFOUND;
            end
         end
         default: ;
      endcase
      res.fill = CNT_W'(shadow_fill);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%t result beat %0d: %s", $realtime, beat_no, what);
   endtask

   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         shadow_fill = 0;
         due_q.delete();
         results_due = 0;
      end else begin
         // results first: a beat offered now never belongs to a request taken now
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat data=%h pos=%0d status=%0d fill=%0d",
                               rsp_item.data, rsp_item.position, rsp_item.status,
                               rsp_item.fill));
            end else begin
               expected = due_q.pop_front();
               if (rsp_item.data !== expected.data || rsp_item.position !== expected.position ||
                   rsp_item.status !== expected.status || rsp_item.fill !== expected.fill)
                  report_mismatch($sformatf(
                     "expected data=%h pos=%0d status=%0d fill=%0d, got data=%h pos=%0d status=%0d fill=%0d",
                     expected.data, expected.position, expected.status, expected.fill,
                     rsp_item.data, rsp_item.position, rsp_item.status, rsp_item.fill));
            end
            beat_no++;
         end
         if (req_valid && !req_stall) due_q.push_back(stack_outcome(req_item));
         results_due = due_q.size();
      end
   end

endmodule

// File: verif/stack_with_search_remove_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the stack unit: clock, reset, stimulus and verdict.
module stack_with_search_remove_unit_tb;
   import swsr_pkg::*;

   // Code 3 is unused by the unit and must behave as a no-op.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Random part is split evenly over five phases.
   localparam int RANDOM_ITEMS = 1830;
   localparam int PHASES       = 5;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_item = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    rsp_stall = 1'b0;

   int mismatches;
   int results_due;
   int idle_pct  = 0;   // chance per cycle that the sender holds back
   int stall_pct = 0;   // chance per cycle that the receiver stalls
   int beats_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stack_with_search_remove_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

   stack_result_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_item    (req_item),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .rsp_stall   (rsp_stall),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   // Receiver back-pressure, redrawn every cycle at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // One request beat: optional idle cycles, then hold the beat until taken.
   // Valid is decided before stall is looked at, and the payload stays put
   // while stalled.
   task automatic send_beat(input logic [1:0] cmd, input logic [DATA_W-1:0] val);
      req_type next_beat;
      next_beat.command = cmd;
      next_beat.value   = val;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= next_beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Sender goes quiet until every outstanding result beat has been seen.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
   endtask

   // Mostly a small pool so removes find matches and duplicates build up;
   // some extremes and some fully random words so every value bit toggles.
   function automatic logic [DATA_W-1:0] pick_value();
      int          r;
      logic [31:0] raw;
      r   = $urandom_range(99);
      raw = $urandom();
      if (r < 70) return DATA_W'($urandom_range(11));
      if (r < 80) begin
         case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(DATA_W-1){1'b0}}};
            default: return DATA_W'(1);
         endcase
      end
      return raw[DATA_W-1:0];
   endfunction

   function automatic logic [1:0] pick_command();
      int r;
      r = $urandom_range(99);
      if (r < 45) return CMD_PUSH;
      if (r < 65) return CMD_POP;
      if (r < 95) return CMD_REMOVE;
      return CMD_UNUSED;
   endfunction

   // Random traffic comes in short episodes so the stack swings between
   // empty and full and removes run over long stacks.
   task automatic run_episode();
      logic [31:0] raw;
      logic [1:0]  cmd;
      case ($urandom_range(9))
         0, 1: begin
            // overfill: runs into the full status from any fill level
            repeat ($urandom_range(72, 66)) send_beat(CMD_PUSH, pick_value());
         end
         2, 3: begin
            // drain, often far enough to hit empty pops
            repeat ($urandom_range(70, 10)) send_beat(CMD_POP, pick_value());
         end
         4, 5, 6: begin
            repeat (20) send_beat(pick_command(), pick_value());
         end
         7: begin
            // sweep every pool key: multiple hits, misses, deep walks
            for (int k = 0; k < 12; k++) send_beat(CMD_REMOVE, DATA_W'(k));
         end
         default: begin
            // noise: any code, any value
            repeat (8) begin
               raw = $urandom();
               cmd = 2'($urandom_range(3));
               send_beat(cmd, raw[DATA_W-1:0]);
            end
         end
      endcase
   endtask

   initial begin
      int phase_end;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-stack corner cases first.
      send_beat(CMD_POP, '1);                        // pop on empty
      send_beat(CMD_REMOVE, DATA_W'(5));             // remove on empty: not found
      send_beat(CMD_UNUSED, '1);                     // no-op on empty
      // build 0, max, 0x2aaaaaaa, max, 0x55555555 (bottom to top)
      send_beat(CMD_PUSH, '0);
      send_beat(CMD_PUSH, '1);
      send_beat(CMD_PUSH, DATA_W'({DATA_W/2{2'b01}}) << 1);
      send_beat(CMD_PUSH, '1);
      send_beat(CMD_PUSH, {1'b1, {DATA_W/2{2'b01}}});
      send_beat(CMD_UNUSED, '0);                     // no-op keeps fill
      send_beat(CMD_REMOVE, '1);                     // two matches, topmost at 2
      send_beat(CMD_REMOVE, {1'b1, {DATA_W/2{2'b01}}}); // match on top
      send_beat(CMD_REMOVE, '0);                     // match at the bottom
      send_beat(CMD_REMOVE, DATA_W'(123));           // miss on non-empty
      send_beat(CMD_POP, '0);                        // pops the last entry
      send_beat(CMD_POP, '0);                        // empty again
      send_beat(CMD_PUSH, '1);
      send_beat(CMD_REMOVE, '1);                     // single entry removed
      drain_results();

      // Random: no idling, sender idle, receiver stalling, both, no idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1:       begin idle_pct = 64; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 64; end
            3:       begin idle_pct = 11; stall_pct = 11; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
         endcase
         phase_end = beats_sent + RANDOM_ITEMS / PHASES;
         while (beats_sent < phase_end) run_episode();
         drain_results();
      end

      // Quiet spell longer than a full-stack remove to catch stray beats.
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
